@@ hdl/spqt_pkg.sv @@
`default_nettype none
package spqt_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int PRIO_W    = 32;
  localparam int TYPE_W    = 3;
  localparam int WORD_W    = 64;
  localparam int ENTRY_W   = PRIO_W + TYPE_W + WORD_W;
  localparam int COUNT_W   = 5;
  localparam int IN_W      = 104;
  localparam int OUT_W     = 80;

  localparam logic [TYPE_W-1:0] TYPE_INT    = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_DOUBLE = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_CHAR   = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_BOOL   = 3'd3;

  typedef enum logic [1:0] {
    KIND_INSERT, KIND_REMOVE, KIND_SEARCH, KIND_UPDATE
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK, ST_FULL, ST_UNKNOWN, ST_NOTHING
  } status_t;

  typedef enum logic [1:0] {
    CMP_NONE, CMP_HIT, CMP_UNKNOWN
  } cmp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_INS_WALK, S_INS_LAST, S_WALK, S_SHIFT, S_DONE
  } state_t;

  typedef struct packed {
    logic   accept;
    logic   load_out;
    state_t op;
  } ctrl_t;

  typedef struct packed {
    logic  count_zero;
    logic  full;
    logic  last;
    logic  idx_zero;
    logic  ins_shift;
    cmp_t  cmp;
    kind_t kind;
    logic  out_busy;
  } stat_t;

  function automatic logic is_nan(input logic [WORD_W-1:0] x);
    return x[WORD_W-2:0] > 63'h7FF0000000000000;
  endfunction

  function automatic cmp_t compare_value(input logic [TYPE_W-1:0] t,
                                         input logic [WORD_W-1:0] stored,
                                         input logic [WORD_W-1:0] req);
    cmp_t r;
    r = CMP_NONE;
    case (t)
      TYPE_INT: begin
        if (stored == req) r = CMP_HIT;
      end
      TYPE_DOUBLE: begin
        if (!is_nan(stored) && !is_nan(req)) begin
          if (stored == req) r = CMP_HIT;
          else if (stored[WORD_W-2:0] == '0 && req[WORD_W-2:0] == '0) r = CMP_HIT;
        end
      end
      TYPE_CHAR: begin
        if (stored[7:0] == req[7:0]) r = CMP_HIT;
      end
      TYPE_BOOL: begin
        if (stored[0] == req[0]) r = CMP_HIT;
      end
      default: r = CMP_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/spqt_ram.sv @@
`default_nettype none
module spqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ hdl/spqt_ctrl.sv @@
`default_nettype none
module spqt_ctrl
  import spqt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    ctrl.accept   = 1'b0;
    ctrl.load_out = 1'b0;
    ctrl.op       = state;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.accept = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.kind == KIND_INSERT) begin
          if (stat.full) state_next = S_DONE;
          else if (stat.count_zero) state_next = S_INS_LAST;
          else state_next = S_INS_WALK;
        end else begin
          if (stat.count_zero) state_next = S_DONE;
          else state_next = S_WALK;
        end
      end
      S_INS_WALK: begin
        if (!stat.ins_shift) state_next = S_DONE;
        else if (stat.idx_zero) state_next = S_INS_LAST;
      end
      S_INS_LAST: state_next = S_DONE;
      S_WALK: begin
        case (stat.cmp)
          CMP_UNKNOWN: state_next = S_DONE;
          CMP_HIT: begin
            if (stat.kind == KIND_REMOVE && !stat.last) state_next = S_SHIFT;
            else state_next = S_DONE;
          end
          default: begin
            if (stat.last) state_next = S_DONE;
          end
        endcase
      end
      S_SHIFT: begin
        if (stat.last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/spqt_datapath.sv @@
`default_nettype none
module spqt_datapath
  import spqt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic [1:0]       s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata,
  input  wire ctrl_t            ctrl,
  output stat_t                 stat
);
  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(DEPTH + 1);

  logic [IW-1:0]      count, idx, idx_p1, idx_m1, cnt_m1;
  kind_t              req_kind;
  logic [PRIO_W-1:0]  req_prio;
  logic [TYPE_W-1:0]  req_type;
  logic [WORD_W-1:0]  req_word;
  status_t            res_status;
  logic               res_found;
  logic [TYPE_W-1:0]  res_type;
  logic [WORD_W-1:0]  res_word;
  logic               out_valid;

  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data, new_entry;
  logic [PRIO_W-1:0]  rd_prio;
  logic [TYPE_W-1:0]  rd_type;
  logic [WORD_W-1:0]  rd_word;
  cmp_t               cmp;

  assign idx_p1    = idx + 1'b1;
  assign idx_m1    = idx - 1'b1;
  assign cnt_m1    = count - 1'b1;
  assign new_entry = {req_word, req_type, req_prio};
  assign rd_prio   = rd_data[PRIO_W-1:0];
  assign rd_type   = rd_data[PRIO_W+TYPE_W-1:PRIO_W];
  assign rd_word   = rd_data[ENTRY_W-1:PRIO_W+TYPE_W];
  assign cmp       = (rd_prio == req_prio) ? compare_value(rd_type, rd_word, req_word)
                                           : CMP_NONE;

  assign stat.count_zero = (count == '0);
  assign stat.full       = (count == IW'(DEPTH));
  assign stat.last       = (idx_p1 == count);
  assign stat.idx_zero   = (idx == '0);
  assign stat.ins_shift  = $signed(rd_prio) < $signed(req_prio);
  assign stat.cmp        = cmp;
  assign stat.kind       = req_kind;
  assign stat.out_busy   = out_valid && !m_tready;

  assign m_tvalid = out_valid;

  spqt_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = new_entry;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (ctrl.op)
      S_DISPATCH: begin
        rd_en   = 1'b1;
        rd_addr = (req_kind == KIND_INSERT) ? cnt_m1[AW-1:0] : '0;
      end
      S_INS_WALK: begin
        wr_en   = 1'b1;
        wr_addr = idx_p1[AW-1:0];
        wr_data = stat.ins_shift ? rd_data : new_entry;
        rd_en   = 1'b1;
        rd_addr = idx_m1[AW-1:0];
      end
      S_INS_LAST: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      S_WALK: begin
        rd_en   = 1'b1;
        rd_addr = idx_p1[AW-1:0];
        if (cmp == CMP_HIT && req_kind == KIND_UPDATE) begin
          wr_en   = 1'b1;
          wr_data = {req_word, req_type, rd_prio};
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_m1[AW-1:0];
        wr_data = rd_data;
        rd_en   = 1'b1;
        rd_addr = idx_p1[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.load_out) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
      case (ctrl.op)
        S_INS_WALK: if (!stat.ins_shift) count <= count + 1'b1;
        S_INS_LAST: count <= count + 1'b1;
        S_WALK: begin
          if (cmp == CMP_HIT && req_kind == KIND_REMOVE && stat.last) count <= cnt_m1;
        end
        S_SHIFT: if (stat.last) count <= cnt_m1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      req_kind <= kind_t'(s_tuser);
      req_prio <= s_tdata[PRIO_W-1:0];
      req_type <= s_tdata[PRIO_W+TYPE_W-1:PRIO_W];
      req_word <= s_tdata[ENTRY_W-1:PRIO_W+TYPE_W];
    end
    case (ctrl.op)
      S_DISPATCH: begin
        idx        <= (req_kind == KIND_INSERT) ? cnt_m1 : '0;
        res_found  <= 1'b0;
        res_type   <= '0;
        res_word   <= '0;
        if (req_kind == KIND_INSERT && stat.full) res_status <= ST_FULL;
        else if (req_kind == KIND_UPDATE && stat.count_zero) res_status <= ST_NOTHING;
        else res_status <= ST_OK;
      end
      S_INS_WALK: idx <= idx_m1;
      S_WALK: begin
        idx <= idx_p1;
        case (cmp)
          CMP_UNKNOWN: res_status <= (req_kind == KIND_UPDATE) ? ST_NOTHING : ST_UNKNOWN;
          CMP_HIT: begin
            res_found <= 1'b1;
            res_type  <= rd_type;
            res_word  <= rd_word;
          end
          default: begin
            if (stat.last && req_kind == KIND_UPDATE) res_status <= ST_NOTHING;
          end
        endcase
      end
      S_SHIFT: idx <= idx_p1;
      default: ;
    endcase
    if (ctrl.load_out) begin
      m_tdata <= {5'b0, COUNT_W'(count), res_word, res_type, res_found, res_status};
    end
  end
endmodule
`default_nettype wire

@@ hdl/sorted_priority_queue_table_unit.sv @@
// Sorted priority table: up to DEPTH tagged entries in descending priority,
// equal priorities in arrival order.
// Request channel s_*: tuser carries the kind (insert, remove, search,
// update); tdata carries priority, type tag and value word.
// Result channel m_*: one result per request with status, found flag, the
// matched entry's tag and word, and the entry count after the request.
// One request is in work at a time; s_tready is high only while idle.
// The entries sit in one RAM with a registered read, walked one entry per
// cycle by the controller:
//   insert: shift the held entries of lower priority up, then write the new one
//   remove: walk to the match, then shift the tail down over it
//   search, update: walk until the match or the last entry held
//   insert into a full table or another request on an empty one: no walk
// A result sits in the output register until taken; a stalled receiver
// holds the block in its final state, and the next request is accepted
// once the result has moved into the output register.
// Reset empties the table and drops a pending result; the RAM is not cleared.
`default_nettype none
module sorted_priority_queue_table_unit
  import spqt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // [31:0] priority_req, [34:32] value_type, [98:35] value_word
  input  wire logic [IN_W-1:0]  s_tdata,
  // [1:0] kind
  input  wire logic [1:0]       s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // [1:0] status, [2] found, [5:3] match_type, [69:6] match_word,
  // [74:70] entry_count
  output logic      [OUT_W-1:0] m_tdata
);
  ctrl_t ctrl;
  stat_t stat;

  spqt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  spqt_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .ctrl     (ctrl),
    .stat     (stat)
  );
endmodule
`default_nettype wire

@@ hdl/spqt_checker.sv @@
`default_nettype none
module spqt_checker
  import spqt_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1:0] == ST_OK)
    else $error("found with error status");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[69:3] == '0)
    else $error("match fields set without a match");
endmodule

bind sorted_priority_queue_table_unit spqt_checker u_chk (.*);
`default_nettype wire
